/* src/ftva_pkg.sv */
// Shared types and constants for the flow to velocity accumulator.
`timescale 1ns / 1ps

package ftva_pkg;

    localparam int MAX_POINTS_DEF = 128;

    localparam logic [15:0] FOCAL_RST  = 16'd8192;
    localparam logic [15:0] CX_RST     = 16'd5120;
    localparam logic [15:0] CY_RST     = 16'd3840;
    localparam logic [7:0]  MARGIN_RST = 8'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_FOCAL  = 2'd0;
    localparam logic [1:0] REG_CX     = 2'd1;
    localparam logic [1:0] REG_CY     = 2'd2;
    localparam logic [1:0] REG_MARGIN = 2'd3;

    // Datapath operations, one per controller step.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DX,
        OP_DIVT_START,
        OP_WYF,
        OP_WZY,
        OP_XY,
        OP_XX,
        OP_WXXY,
        OP_WYXX,
        OP_NUM,
        OP_DIVF_START,
        OP_BSUM,
        OP_B8,
        OP_VX,
        OP_DIVVF_START,
        OP_BH,
        OP_DIVBH_START,
        OP_ACC,
        OP_DIVN_START,
        OP_OUT,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic point_ok;
        logic cnt_zero;
    } t_stat;

endpackage

/* src/ftva_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module ftva_div #(
    parameter int W = 72
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_quo
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_trial;
    logic [W-1:0]  w_shift;

    // Restoring division step on magnitudes.
    always_comb begin
        w_shift = {r_rem[W-2:0], r_quo[W-1]};
        w_trial = {1'b0, w_shift} - {1'b0, r_den};
        n_quo   = {r_quo[W-2:0], ~w_trial[W]};
        n_rem   = w_trial[W] ? w_shift : w_trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_rem  <= '0;
                r_quo  <= i_num[W-1] ? W'(-i_num) : W'(i_num);
                r_den  <= i_den[W-1] ? W'(-i_den) : W'(i_den);
                r_neg  <= i_num[W-1] ^ i_den[W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? W'(-r_quo) : W'(r_quo);

endmodule

/* src/ftva_datapath.sv */
// Datapath: operand registers, the multiplies, a shared divider and the sums.
`timescale 1ns / 1ps

module ftva_datapath #(
    parameter int MAX_POINTS = ftva_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftva_pkg::t_cmd      i_cmd,
    output ftva_pkg::t_stat     o_stat,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic [164:0]        i_item,
    output logic [87:0]         o_result
);

    localparam int DW = 72;
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    logic [15:0] r_focal, r_cx, r_cy;
    logic [7:0]  r_margin;

    logic signed [17:0] r_px, r_py, r_x, r_y;
    logic               r_tracked;
    logic [19:0]        r_t;
    logic signed [15:0] r_wx, r_wy, r_wz, r_v;
    logic [15:0]        r_h;
    logic               r_ok;

    logic signed [DW-1:0] r_acc, r_a, r_b, r_p;
    logic signed [47:0]   r_sx, r_sy;
    logic signed [47:0]   r_vpart;
    logic signed [31:0]   r_ox, r_oy;
    logic [CNTW-1:0]      r_cnt;

    logic                 w_start;
    logic signed [DW-1:0] w_num, w_den, w_quo;
    logic                 w_done;
    logic signed [DW-1:0] w_f;
    logic signed [DW-1:0] w_sat;
    logic signed [18:0]   w_lx, w_ly;
    logic signed [17:0]   w_ax, w_ay;
    logic signed [17:0]   w_cx, w_cy, w_c, w_pc;

    assign w_f = (r_focal == '0) ? DW'(1) : DW'(r_focal);

    function automatic logic signed [DW-1:0] sat32(input logic signed [DW-1:0] v);
        if (v > DW'(64'sd2147483647))       sat32 = DW'(64'sd2147483647);
        else if (v < -DW'(64'sd2147483648)) sat32 = -DW'(64'sd2147483648);
        else                                sat32 = v;
    endfunction

    assign w_sat = sat32(w_quo);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= ftva_pkg::FOCAL_RST;
            r_cx     <= ftva_pkg::CX_RST;
            r_cy     <= ftva_pkg::CY_RST;
            r_margin <= ftva_pkg::MARGIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftva_pkg::REG_FOCAL:  r_focal  <= i_cfg_data;
                ftva_pkg::REG_CX:     r_cx     <= i_cfg_data;
                ftva_pkg::REG_CY:     r_cy     <= i_cfg_data;
                ftva_pkg::REG_MARGIN: r_margin <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Border limits and acceptance test on the loaded point.
    assign w_lx = 19'(r_cx) - 19'({r_margin, 4'b0});
    assign w_ly = 19'(r_cy) - 19'({r_margin, 4'b0});
    assign w_ax = r_x[17] ? -r_x : r_x;
    assign w_ay = r_y[17] ? -r_y : r_y;
    assign w_cx = i_cmd.axis ? r_y : r_x;
    assign w_cy = i_cmd.axis ? r_x : r_y;
    assign w_c  = w_cx;
    assign w_pc = i_cmd.axis ? r_py : r_px;

    // Divider operand selection.
    always_comb begin
        w_start = 1'b0;
        w_num   = r_acc;
        w_den   = w_f;
        case (i_cmd.op)
            ftva_pkg::OP_DIVT_START: begin
                w_start = 1'b1;
                w_den   = (r_t == '0) ? DW'(1) : DW'(r_t);
            end
            ftva_pkg::OP_DIVF_START, ftva_pkg::OP_DIVVF_START: w_start = 1'b1;
            ftva_pkg::OP_DIVBH_START: begin
                w_start = 1'b1;
                w_den   = w_f <<< 4;
            end
            ftva_pkg::OP_DIVN_START: begin
                w_start = 1'b1;
                w_num   = i_cmd.axis ? DW'(r_sy) : DW'(r_sx);
                w_den   = DW'(r_cnt);
            end
            default: ;
        endcase
    end

    ftva_div #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    // Sequenced arithmetic; each step holds at most one multiply.
    // For the Y axis the roles of x and y swap and the rate terms change sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_ok  <= 1'b0;
        end else begin
            case (i_cmd.op)
                ftva_pkg::OP_LOAD: begin
                    r_px      <= 18'(i_item[15:0])   - 18'(r_cx);
                    r_py      <= 18'(i_item[31:16])  - 18'(r_cy);
                    r_x       <= 18'(i_item[47:32])  - 18'(r_cx);
                    r_y       <= 18'(i_item[63:48])  - 18'(r_cy);
                    r_tracked <= i_item[64];
                    r_t       <= i_item[84:65];
                    r_wx      <= i_item[100:85];
                    r_wy      <= i_item[116:101];
                    r_wz      <= i_item[132:117];
                    r_h       <= i_item[148:133];
                end
                ftva_pkg::OP_DX: begin
                    r_ok  <= r_tracked && (r_cnt < CNTW'(MAX_POINTS)) &&
                             !(19'(w_ax) > w_lx) && !(19'(w_ay) > w_ly);
                    r_acc <= -((DW'(w_c) - DW'(w_pc)) * DW'(64'sd4096000000));
                end
                ftva_pkg::OP_WYF: begin
                    r_b <= w_quo;
                    r_p <= (i_cmd.axis ? DW'(r_wx) : -DW'(r_wy)) * w_f;
                end
                ftva_pkg::OP_WZY: begin
                    // x axis: +wz*y, y axis: -wz*x
                    r_b <= r_b + r_p;
                    r_p <= i_cmd.axis ? -(DW'(r_wz) * DW'(w_cy)) : DW'(r_wz) * DW'(w_cy);
                end
                ftva_pkg::OP_XY: begin
                    r_b <= r_b + r_p;
                    r_a <= DW'(r_x) * DW'(r_y);
                end
                ftva_pkg::OP_XX: begin
                    r_p <= DW'(w_c) * DW'(w_c);
                end
                ftva_pkg::OP_WXXY: begin
                    // x axis: wx*x*y, y axis: wx*y*y
                    r_acc <= DW'(r_wx) * (i_cmd.axis ? r_p : r_a);
                end
                ftva_pkg::OP_WYXX: begin
                    r_p <= DW'(r_wy) * (i_cmd.axis ? r_a : r_p);
                end
                ftva_pkg::OP_NUM: r_acc <= r_acc - r_p;
                ftva_pkg::OP_BSUM: r_b <= r_b + w_quo;
                ftva_pkg::OP_B8: begin
                    r_b   <= (r_b < 0) ? -((-r_b) >>> 8) : (r_b >>> 8);
                    r_acc <= DW'(r_v) * DW'(w_c);
                end
                ftva_pkg::OP_BH: begin
                    r_vpart <= 48'(w_quo);
                    r_acc   <= r_b * DW'(r_h);
                end
                ftva_pkg::OP_ACC: begin
                    if (r_ok) begin
                        if (i_cmd.axis) r_sy <= r_sy + 48'(sat32(DW'(r_vpart) + w_quo));
                        else            r_sx <= r_sx + 48'(sat32(DW'(r_vpart) + w_quo));
                        if (i_cmd.axis) r_cnt <= r_cnt + 1'b1;
                    end
                end
                ftva_pkg::OP_OUT: begin
                    if (i_cmd.axis) r_oy <= 32'(w_sat);
                    else            r_ox <= 32'(w_sat);
                end
                ftva_pkg::OP_CLEAR: begin
                    r_sx  <= '0;
                    r_sy  <= '0;
                    r_cnt <= '0;
                end
                default: ;
            endcase
        end
    end

    // Climb rate is kept apart since it travels in the top bits of the item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ftva_pkg::OP_LOAD) r_v <= i_item[164:149];
    end

    assign o_stat.div_done = w_done;
    assign o_stat.point_ok = r_ok;
    assign o_stat.cnt_zero = (r_cnt == '0);

    assign o_result = (r_cnt == '0) ? 88'(8'(r_cnt)) << 80 :
                      {8'(r_cnt), r_v, r_oy, r_ox};

endmodule

/* src/ftva_ctrl.sv */
// Controller: sequences the datapath steps for each item, and the averages and output at frame end.
`timescale 1ns / 1ps

module ftva_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_last,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ftva_pkg::t_stat i_stat,
    output ftva_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DX, S_DIVT, S_WAITT, S_WYF, S_WZY, S_XY, S_XX, S_WXXY, S_WYXX,
        S_NUM, S_DIVF, S_WAITF, S_BSUM, S_B8, S_DIVVF, S_WAITVF, S_BH, S_DIVBH,
        S_WAITBH, S_ACC, S_END, S_DIVN, S_WAITN, S_OUT, S_HOLD
    } t_state;

    t_state r_state;
    logic   r_axis, r_last, r_outv;

    assign o_in_ready  = (r_state == S_IDLE) && !r_outv;
    assign o_out_valid = r_outv;

    always_comb begin
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE:   o_cmd.op = (i_in_valid && !r_outv) ? ftva_pkg::OP_LOAD
                                                         : ftva_pkg::OP_NONE;
            S_DX:     o_cmd.op = ftva_pkg::OP_DX;
            S_DIVT:   o_cmd.op = ftva_pkg::OP_DIVT_START;
            S_WYF:    o_cmd.op = ftva_pkg::OP_WYF;
            S_WZY:    o_cmd.op = ftva_pkg::OP_WZY;
            S_XY:     o_cmd.op = ftva_pkg::OP_XY;
            S_XX:     o_cmd.op = ftva_pkg::OP_XX;
            S_WXXY:   o_cmd.op = ftva_pkg::OP_WXXY;
            S_WYXX:   o_cmd.op = ftva_pkg::OP_WYXX;
            S_NUM:    o_cmd.op = ftva_pkg::OP_NUM;
            S_DIVF:   o_cmd.op = ftva_pkg::OP_DIVF_START;
            S_BSUM:   o_cmd.op = ftva_pkg::OP_BSUM;
            S_B8:     o_cmd.op = ftva_pkg::OP_B8;
            S_DIVVF:  o_cmd.op = ftva_pkg::OP_DIVVF_START;
            S_BH:     o_cmd.op = ftva_pkg::OP_BH;
            S_DIVBH:  o_cmd.op = ftva_pkg::OP_DIVBH_START;
            S_ACC:    o_cmd.op = ftva_pkg::OP_ACC;
            S_DIVN:   o_cmd.op = ftva_pkg::OP_DIVN_START;
            S_OUT:    o_cmd.op = i_stat.div_done ? ftva_pkg::OP_OUT : ftva_pkg::OP_NONE;
            S_HOLD:   o_cmd.op = (r_outv && i_out_ready) ? ftva_pkg::OP_CLEAR
                                                         : ftva_pkg::OP_NONE;
            default:  o_cmd.op = ftva_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
            r_last  <= 1'b0;
            r_outv  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid && !r_outv) begin
                    r_last  <= i_last;
                    r_axis  <= 1'b0;
                    r_state <= S_DX;
                end
                S_DX:     r_state <= S_DIVT;
                S_DIVT:   r_state <= S_WAITT;
                S_WAITT:  if (i_stat.div_done) r_state <= S_WYF;
                S_WYF:    r_state <= S_WZY;
                S_WZY:    r_state <= S_XY;
                S_XY:     r_state <= S_XX;
                S_XX:     r_state <= S_WXXY;
                S_WXXY:   r_state <= S_WYXX;
                S_WYXX:   r_state <= S_NUM;
                S_NUM:    r_state <= S_DIVF;
                S_DIVF:   r_state <= S_WAITF;
                S_WAITF:  if (i_stat.div_done) r_state <= S_BSUM;
                S_BSUM:   r_state <= S_B8;
                S_B8:     r_state <= S_DIVVF;
                S_DIVVF:  r_state <= S_WAITVF;
                S_WAITVF: if (i_stat.div_done) r_state <= S_BH;
                S_BH:     r_state <= S_DIVBH;
                S_DIVBH:  r_state <= S_WAITBH;
                S_WAITBH: if (i_stat.div_done) r_state <= S_ACC;
                S_ACC: begin
                    r_axis <= ~r_axis;
                    if (!r_axis) r_state <= S_DX;
                    else if (r_last) r_state <= S_END;
                    else r_state <= S_IDLE;
                end
                S_END: begin
                    r_axis  <= 1'b0;
                    r_state <= i_stat.cnt_zero ? S_HOLD : S_DIVN;
                    r_outv  <= i_stat.cnt_zero;
                end
                S_DIVN:   r_state <= S_OUT;
                S_OUT: if (i_stat.div_done) begin
                    if (r_axis) begin
                        r_state <= S_HOLD;
                        r_outv  <= 1'b1;
                    end else begin
                        r_state <= S_DIVN;
                    end
                    r_axis <= ~r_axis;
                end
                S_HOLD: if (r_outv && i_out_ready) begin
                    r_outv  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result waits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_HOLD))
        else $error("result shown outside hold state");

endmodule

/* src/flow_to_velocity_accumulator.sv */
// Top level of the flow to velocity accumulator.
// Each item is processed for two axes, each with four divisions on the shared
// bit-serial divider; a new item is accepted only once the last one is done.
// At frame end two more divisions form the averages (none if no point counted),
// and the result is then held valid; input waits until the result is taken.
// Reset (synchronous, active low) clears sums, count and control state and
// restores the register defaults.
`timescale 1ns / 1ps

module flow_to_velocity_accumulator #(
    parameter int MAX_POINTS = ftva_pkg::MAX_POINTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // prev_px_x, prev_px_y, cur_px_x, cur_px_y, tracked, frame_interval,
    // rate_x, rate_y, rate_z, height, climb_rate, zero fill
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vel_x, vel_y, vel_z, valid_count
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    ftva_pkg::t_cmd  w_cmd;
    ftva_pkg::t_stat w_stat;
    logic [164:0]    w_item;

    // The datapath takes the packed fields without the zero fill.
    assign w_item = s_axis_tdata[164:0];

    ftva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ftva_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (w_item),
        .o_result   (m_axis_tdata)
    );

endmodule
